### sv/sprl_pkg.sv
`default_nettype none
package sprl_pkg;

   localparam int LOCAL_VERTS = 1024;
   localparam int EDGE_SLOTS  = 4096;
   localparam int MAX_DEGREE  = 64;
   localparam int PARTS       = 8;

   localparam int VTX_W  = 20;
   localparam int DIST_W = 31;
   localparam int WT_W   = 10;
   localparam int PIDX_W = 3;
   localparam int LIM_W  = 21;
   localparam int PCNT_W = 4;
   localparam int CSR_W  = 21;

   localparam int LV_W   = $clog2(LOCAL_VERTS);
   localparam int EDGE_W = $clog2(EDGE_SLOTS);
   localparam int FILL_W = EDGE_W + 1;
   localparam int CNT_W  = $clog2(MAX_DEGREE) + 1;
   localparam int PJ_W   = $clog2(PARTS) + 1;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [1:0] {
      MODE_PART  = 2'd0,
      MODE_EDGE  = 2'd1,
      MODE_RELAX = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_LOCAL_BASE   = 2'd0,
      CSR_VERTEX_LIMIT = 2'd1,
      CSR_PART_COUNT   = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FETCH,
      ST_SUM,
      ST_ROUTE
   } state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [VTX_W-1:0]  vertex;
      logic [DIST_W-1:0] distance;
      logic [VTX_W-1:0]  edge_end;
      logic [WT_W-1:0]   edge_weight;
      logic [PIDX_W-1:0] part_index;
      logic [VTX_W-1:0]  part_start;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0]  neighbor;
      logic [DIST_W-1:0] new_distance;
      logic [PIDX_W-1:0] dest_part;
      logic              in_range;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [VTX_W-1:0] neighbor;
   } route_req_type;

   typedef struct packed {
      logic              done;
      logic [PIDX_W-1:0] part;
   } route_rsp_type;

endpackage
`default_nettype wire

### sv/sprl_route.sv
`default_nettype none
module sprl_route import sprl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tbl_we,
   input  wire logic [PIDX_W-1:0] tbl_index,
   input  wire logic [VTX_W-1:0]  tbl_data,
   input  wire logic [PCNT_W-1:0] part_count,
   input  wire route_req_type     req,
   output route_rsp_type          rsp
);

   logic [VTX_W-1:0]  tbl_ff [PARTS];
   logic              active_ff, active_in;
   logic [PJ_W-1:0]   j_ff, j_in;
   logic [PIDX_W-1:0] p_ff, p_in;
   logic [VTX_W-1:0]  nb_ff, nb_in;
   logic [PJ_W-1:0]   limit;
   logic              stop;

   always_ff @(posedge clock) begin
      if (tbl_we && 32'(tbl_index) < PARTS) begin
         tbl_ff[tbl_index] <= tbl_data;
      end
   end

   always_comb begin
      limit = (32'(part_count) > PARTS) ? PJ_W'(PARTS) : PJ_W'(part_count);
      // One partition boundary is compared per cycle; the search ends at the
      // first boundary above the neighbor or at the end of the table.
      stop = (j_ff >= limit) || (nb_ff < tbl_ff[j_ff[PJ_W-2:0]]);
      rsp.done = active_ff && stop;
      rsp.part = p_ff;
      active_in = active_ff;
      j_in = j_ff;
      p_in = p_ff;
      nb_in = nb_ff;
      if (req.start) begin
         active_in = 1'b1;
         j_in = PJ_W'(1);
         p_in = '0;
         nb_in = req.neighbor;
      end else if (active_ff) begin
         if (stop) begin
            active_in = 1'b0;
         end else begin
            j_in = j_ff + PJ_W'(1);
            p_in = p_ff + PIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      j_ff <= j_in;
      p_ff <= p_in;
      nb_ff <= nb_in;
   end

endmodule
`default_nettype wire

### sv/shortest_path_relax_engine_top.sv
`default_nettype none
// Distance relaxation engine for one partition of a weighted graph.
// Items enter on req_data when start is high and busy is low. Mode 0 writes a
// partition start, mode 1 appends an edge of a local source vertex, mode 2
// offers a vertex a candidate distance; mode 3 is dropped.
// Mode 0 is taken at once and leaves busy low. A mode 1 item holds busy high
// while it passes through the lookup state. A relax reads the distance in the
// lookup state, then for each neighbor fetches the edge, sums the distance and
// searches the partition table, one compare per boundary passed (up to
// part_count - 1, with part_count above 8 counted as 8), before its result.
// The single distance/adjacency memory port and the one-compare-per-cycle
// partition search set the pace of a relax.
// Each result appears on rsp_data for one cycle with rsp_valid high; the
// receiver cannot stall, so none is held. The last result of a relax has
// rsp_data.last set.
// The csr_ port writes local_base, vertex_limit and part_count; the user must write them while idle, unenforced here.
// After reset the block clears all 1024 entries of its distance and degree stores,
// one entry a cycle, with busy high; configuration writes are taken.
module shortest_path_relax_engine_top import sprl_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   logic [DIST_W-1:0] dist_mem  [LOCAL_VERTS];
   logic [CNT_W-1:0]  cnt_mem   [LOCAL_VERTS];
   logic [EDGE_W-1:0] start_mem [LOCAL_VERTS];
   logic [VTX_W-1:0]  dest_mem  [EDGE_SLOTS];
   logic [WT_W-1:0]   wt_mem    [EDGE_SLOTS];

   logic [VTX_W-1:0]  local_base_ff;
   logic [LIM_W-1:0]  vertex_limit_ff;
   logic [PCNT_W-1:0] part_count_ff;

   state_type         state_ff, state_in;
   logic [LV_W-1:0]   clr_ff, clr_in;
   logic [LV_W-1:0]   li_ff, li_in;
   logic [1:0]        mode_ff, mode_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [VTX_W-1:0]  eend_ff, eend_in;
   logic [WT_W-1:0]   ewt_ff, ewt_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [EDGE_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [VTX_W-1:0]  nb_ff, nb_in;
   logic [DIST_W-1:0] sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [DIST_W-1:0] dist_rd;
   logic [CNT_W-1:0]  cnt_rd;
   logic [EDGE_W-1:0] start_rd;
   logic [VTX_W-1:0]  dest_rd;
   logic [WT_W-1:0]   wt_rd;

   logic              accept;
   logic [VTX_W-1:0]  li_full;
   logic              li_ok;
   logic [LV_W-1:0]   rd_addr, wr_addr;
   logic              dist_we, cnt_we, start_we, edge_we;
   logic [DIST_W-1:0] dist_wd;
   logic [CNT_W-1:0]  cnt_wd;
   logic [FILL_W-1:0] slot;
   logic [DIST_W:0]   sum_wide;
   logic              part_we;
   route_req_type     route_req;
   route_rsp_type     route_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_base_ff <= '0;
         vertex_limit_ff <= LIM_W'(1) << VTX_W;
         part_count_ff <= PCNT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOCAL_BASE:   local_base_ff <= csr_wdata[VTX_W-1:0];
            CSR_VERTEX_LIMIT: vertex_limit_ff <= csr_wdata[LIM_W-1:0];
            CSR_PART_COUNT:   part_count_ff <= csr_wdata[PCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[wr_addr] <= dist_wd;
      end
      if (cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wd;
      end
      if (start_we) begin
         start_mem[wr_addr] <= fill_ff[EDGE_W-1:0];
      end
      dist_rd <= dist_mem[rd_addr];
      cnt_rd <= cnt_mem[rd_addr];
      start_rd <= start_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         dest_mem[fill_ff[EDGE_W-1:0]] <= eend_ff;
         wt_mem[fill_ff[EDGE_W-1:0]] <= ewt_ff;
      end
      dest_rd <= dest_mem[slot[EDGE_W-1:0]];
      wt_rd <= wt_mem[slot[EDGE_W-1:0]];
   end

   sprl_route u_route (
      .clock      (clock),
      .reset      (reset),
      .tbl_we     (part_we),
      .tbl_index  (req_data.part_index),
      .tbl_data   (req_data.part_start),
      .part_count (part_count_ff),
      .req        (route_req),
      .rsp        (route_rsp)
   );

   always_comb begin
      busy = (state_ff != ST_IDLE);
      accept = start && !busy;
      li_full = req_data.vertex - local_base_ff;
      li_ok = (32'(li_full) < LOCAL_VERTS);
      rd_addr = li_full[LV_W-1:0];
      part_we = accept && (mode_type'(req_data.mode) == MODE_PART);
      slot = FILL_W'(base_ff) + FILL_W'(k_ff);
      sum_wide = {1'b0, dist_ff} + (DIST_W + 1)'(wt_rd);

      state_in = state_ff;
      clr_in = clr_ff;
      li_in = li_ff;
      mode_in = mode_ff;
      dist_in = dist_ff;
      eend_in = eend_ff;
      ewt_in = ewt_ff;
      cnt_in = cnt_ff;
      base_in = base_ff;
      k_in = k_ff;
      fill_in = fill_ff;
      nb_in = nb_ff;
      sum_in = sum_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      wr_addr = li_ff;
      dist_we = 1'b0;
      dist_wd = dist_ff;
      cnt_we = 1'b0;
      cnt_wd = cnt_rd + CNT_W'(1);
      start_we = 1'b0;
      edge_we = 1'b0;
      route_req.start = 1'b0;
      route_req.neighbor = dest_rd;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr = clr_ff;
            dist_we = 1'b1;
            dist_wd = DIST_MAX;
            cnt_we = 1'b1;
            cnt_wd = '0;
            clr_in = clr_ff + LV_W'(1);
            if (32'(clr_ff) == LOCAL_VERTS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               li_in = li_full[LV_W-1:0];
               mode_in = req_data.mode;
               dist_in = req_data.distance;
               eend_in = req_data.edge_end;
               ewt_in = req_data.edge_weight;
               if (li_ok && (mode_type'(req_data.mode) == MODE_EDGE ||
                             mode_type'(req_data.mode) == MODE_RELAX)) begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
            if (mode_type'(mode_ff) == MODE_EDGE) begin
               if (32'(fill_ff) < EDGE_SLOTS && 32'(cnt_rd) < MAX_DEGREE) begin
                  start_we = (cnt_rd == '0);
                  edge_we = 1'b1;
                  cnt_we = 1'b1;
                  fill_in = fill_ff + FILL_W'(1);
               end
            end else if (dist_ff < dist_rd) begin
               dist_we = 1'b1;
               cnt_in = cnt_rd;
               base_in = start_rd;
               k_in = '0;
               if (cnt_rd != '0) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // A list that runs past the end of the edge store stops early.
            if (slot[EDGE_W]) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            nb_in = dest_rd;
            sum_in = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
            route_req.start = 1'b1;
            state_in = ST_ROUTE;
         end
         ST_ROUTE: begin
            if (route_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_in.neighbor = nb_ff;
               rsp_in.new_distance = sum_ff;
               rsp_in.dest_part = route_rsp.part;
               rsp_in.in_range = (nb_ff != '0) && (LIM_W'(nb_ff) < vertex_limit_ff);
               rsp_in.last = (k_ff + CNT_W'(1) == cnt_ff);
               k_in = k_ff + CNT_W'(1);
               state_in = rsp_in.last ? ST_IDLE : ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      li_ff <= li_in;
      mode_ff <= mode_in;
      dist_ff <= dist_in;
      eend_ff <= eend_in;
      ewt_ff <= ewt_in;
      cnt_ff <= cnt_in;
      base_ff <= base_in;
      k_ff <= k_in;
      nb_ff <= nb_in;
      sum_ff <= sum_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire
